### rtl/tpoq_pkg.sv
// Shared types and constants for the task priority ordered queue.
// Holds the entry layout, operation and status codes and the sequencer states.
// No dependencies.
package tpoq_pkg;

  localparam int ID_LIMIT  = 128;  // ids are handed out once each, 1 .. ID_LIMIT
  localparam int MAX_COUNT = 64;   // larger add counts are clamped to this

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_FIND = 2'd1,
    OP_RANK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CHECK,
    S_ADD_SHIFT,
    S_ADD_PLACE,
    S_FIND,
    S_FIND_SCAN,
    S_RANK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] exec_time;
    logic [7:0]  priority_val;
    logic [7:0]  id;
  } entry_t;

endpackage

### rtl/task_priority_ordered_queue.sv
// Task priority ordered queue: sorted task table in one synchronous memory.
// Sequencer walks the memory one entry per cycle for insert and lookup.
// Depends on tpoq_pkg.
//
// Usage:
//   Requests enter on s_tvalid/s_tready. s_tuser carries the op (add, find by
//   id, read at rank); s_tdata carries count, priority, time, id and rank.
//   Results leave on m_tvalid/m_tready with m_tlast on the final result of a
//   request. Order is higher priority, then shorter time, then smaller id.
//   One request is in work at a time; s_tready is high only while idle.
//   Add: for each task the sequencer walks from the tail, shifting every stored
//     entry that ranks behind it up one slot (one entry per cycle through the
//     single read port and single write port); there is no walk into an empty table
//     or when ids run out or the table is full.
//   Find by id: scans entries from the head until the id matches or occupancy ends.
//   Read at rank: an empty rank is answered without a memory read.
//   Results go through an output register; while the receiver stalls the
//   sequencer holds at its emit step and the table is not touched.
//   Reset (rst, synchronous) empties the table and restarts ids at 1; no
//   clearing pass is needed since only entries below occupancy are read.
module task_priority_ordered_queue
  import tpoq_pkg::*;
#(
  parameter int MAX_TASKS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [6:0] count, [14:7] priority_req, [30:15] exec_time, [38:31] task_id,
  // [45:39] rank, [47:46] zero
  input  logic [47:0] s_tdata,
  // [1:0] op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [9:2] out_id, [17:10] out_priority, [33:18] time_left,
  // [39:34] zero
  output logic [39:0] m_tdata,
  output logic        m_tlast
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int OW = $clog2(MAX_TASKS + 1);

  state_t state, state_next;

  // request registers
  logic [6:0]  count_reg;
  logic [7:0]  pri_reg;
  logic [15:0] time_reg;
  logic [7:0]  qid_reg;
  logic [6:0]  rank_reg;
  logic [6:0]  done;

  logic [OW-1:0] occ;
  logic [7:0]    next_free_id;
  logic [AW-1:0] ptr, ptr_next;

  // staged result
  status_t res_status;
  entry_t  res_entry;
  logic    res_last;

  // memory
  entry_t        mem [MAX_TASKS];
  entry_t        rd_data, wr_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  logic    commit, res_ld, out_ld, slot_free, last_task, occ_full;
  status_t res_st_in;
  entry_t  res_ent_in;
  logic    res_last_in;
  entry_t  new_entry;
  logic [6:0] in_count;

  // rank read lands in rd_data in the following cycle; flag it so emit takes it
  logic rank_pending;

  function automatic logic goes_before(entry_t a, entry_t b);
    if (a.priority_val != b.priority_val) return a.priority_val > b.priority_val;
    if (a.exec_time != b.exec_time) return a.exec_time < b.exec_time;
    return a.id < b.id;
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign in_count  = (s_tdata[6:0] > 7'(MAX_COUNT)) ? 7'(MAX_COUNT) : s_tdata[6:0];
  assign last_task = ((done + 7'd1) == count_reg);
  assign occ_full  = (occ == OW'(MAX_TASKS));
  assign new_entry = '{exec_time: time_reg, priority_val: pri_reg, id: next_free_id};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    rd_addr     = ptr;
    wr_en       = 1'b0;
    wr_addr     = ptr;
    wr_data     = new_entry;
    ptr_next    = ptr;
    commit      = 1'b0;
    res_ld      = 1'b0;
    res_st_in   = ST_OK;
    res_ent_in  = '0;
    res_last_in = 1'b1;
    out_ld      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            OP_ADD:  if (in_count != 7'd0) state_next = S_ADD_CHECK;
            OP_FIND: state_next = S_FIND;
            OP_RANK: state_next = S_RANK;
            default: ;
          endcase
        end
      end
      S_ADD_CHECK: begin
        if (next_free_id > 8'(ID_LIMIT) || occ_full) begin
          res_ld     = 1'b1;
          res_st_in  = ST_FULL;
          state_next = S_EMIT;
        end else if (occ == '0) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          commit     = 1'b1;
          state_next = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(occ - 1'b1);
          ptr_next   = AW'(occ - 1'b1);
          state_next = S_ADD_SHIFT;
        end
      end
      S_ADD_SHIFT: begin
        // rd_data holds entry ptr; the next read overlaps the shift write
        wr_en   = 1'b1;
        wr_addr = AW'(ptr + 1'b1);
        if (goes_before(new_entry, rd_data)) begin
          wr_data = rd_data;
          if (ptr == '0) begin
            state_next = S_ADD_PLACE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = AW'(ptr - 1'b1);
            ptr_next = AW'(ptr - 1'b1);
          end
        end else begin
          commit     = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_ADD_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        commit     = 1'b1;
        state_next = S_EMIT;
      end
      S_FIND: begin
        if (occ == '0) begin
          res_ld     = 1'b1;
          res_st_in  = ST_NOT_FOUND;
          state_next = S_EMIT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          ptr_next   = '0;
          state_next = S_FIND_SCAN;
        end
      end
      S_FIND_SCAN: begin
        if (rd_data.id == qid_reg) begin
          res_ld     = 1'b1;
          res_ent_in = rd_data;
          state_next = S_EMIT;
        end else if (ptr == AW'(occ - 1'b1)) begin
          res_ld     = 1'b1;
          res_st_in  = ST_NOT_FOUND;
          state_next = S_EMIT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = AW'(ptr + 1'b1);
          ptr_next = AW'(ptr + 1'b1);
        end
      end
      S_RANK: begin
        if (32'(rank_reg) < 32'(occ)) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(rank_reg);
          // entry is staged through rank_pending before emit sends it
          state_next = S_EMIT;
        end else begin
          res_ld     = 1'b1;
          res_st_in  = ST_NOT_FOUND;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free && !rank_pending) begin
          out_ld     = 1'b1;
          state_next = res_last ? S_IDLE : S_ADD_CHECK;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (commit) begin
      res_ld      = 1'b1;
      res_ent_in  = new_entry;
      res_last_in = last_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= '0;
      next_free_id <= 8'd1;
      m_tvalid     <= 1'b0;
      rank_pending <= 1'b0;
    end else begin
      if (commit) begin
        occ          <= occ + 1'b1;
        next_free_id <= next_free_id + 8'd1;
      end
      rank_pending <= (state == S_RANK) && rd_en;
      if (out_ld)        m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (s_tvalid && s_tready) begin
      count_reg <= in_count;
      pri_reg   <= s_tdata[14:7];
      time_reg  <= s_tdata[30:15];
      qid_reg   <= s_tdata[38:31];
      rank_reg  <= s_tdata[45:39];
      done      <= '0;
    end else if (commit) begin
      done <= done + 7'd1;
    end
    if (res_ld) begin
      res_status <= res_st_in;
      res_entry  <= res_ent_in;
      res_last   <= res_last_in;
    end else if (rank_pending) begin
      res_status <= ST_OK;
      res_entry  <= rd_data;
      res_last   <= 1'b1;
    end
    if (out_ld) begin
      m_tdata <= {6'd0, res_entry.exec_time, res_entry.priority_val, res_entry.id,
                  res_status};
      m_tlast <= res_last;
    end
  end

  // ids are never freed, so every id handed out is still in the table
  a_occ_tracks_ids: assert property (@(posedge clk) disable iff (rst)
    32'(occ) + 1 == 32'(next_free_id))
    else $error("occupancy and next free id out of step");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= MAX_TASKS)
    else $error("occupancy above table size");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("read and write hit the same entry");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD_SHIFT |-> 32'(ptr) < 32'(occ))
    else $error("shift pointer beyond occupied entries");

  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tlast)
    else $error("table full result not marked last");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for task_priority_ordered_queue: directed table, then random requests.
// Expected results come from an in-bench model of the sorted task table; depends on tpoq_pkg.
module testbench;
  import tpoq_pkg::*;

  localparam int TABLE_DEPTH  = 128;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  count;
    logic [7:0]  pri;
    logic [15:0] tm;
    logic [7:0]  id;
    logic [6:0]  rank;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  id;
    logic [7:0]  pri;
    logic [15:0] tm;
    logic        last;
  } task_result_t;

  typedef struct packed {
    request_t     req;
    logic         typed;
    task_result_t res;
  } directed_row_t;

  localparam task_result_t MISS = '{ST_NOT_FOUND, 8'd0, 8'd0, 16'd0, 1'b1};
  localparam task_result_t NONE = '{ST_OK, 8'd0, 8'd0, 16'd0, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  task_priority_ordered_queue #(.MAX_TASKS(TABLE_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the sorted waiting table
  logic [7:0]  held_id   [TABLE_DEPTH];
  logic [7:0]  held_pri  [TABLE_DEPTH];
  logic [15:0] held_time [TABLE_DEPTH];
  int          occupied = 0;
  int          next_task_id = 1;

  task_result_t pending_results[$];
  int  error_count = 0;
  int  checked_count = 0;
  int  full_hits = 0;
  int  add_count = 0, find_count = 0, rank_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  task automatic flag_error(input string msg);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Apply one accepted request to the shadow table and queue its results.
  task automatic schedule_results(input request_t r);
    int n, k, pos, j;
    bit ahead;
    case (r.op)
      OP_ADD: begin
        add_count++;
        n = (r.count > MAX_COUNT) ? MAX_COUNT : r.count;
        for (k = 0; k < n; k++) begin
          if (next_task_id > ID_LIMIT || occupied >= TABLE_DEPTH) begin
            pending_results.push_back('{ST_FULL, 8'd0, 8'd0, 16'd0, 1'b1});
            full_hits++;
            break;
          end
          // first slot that the new task outranks; equal entries stay ahead
          for (pos = 0; pos < occupied; pos++) begin
            ahead = (r.pri != held_pri[pos]) ? (r.pri > held_pri[pos]) :
                    (r.tm != held_time[pos]) ? (r.tm < held_time[pos]) :
                    (next_task_id < held_id[pos]);
            if (ahead) break;
          end
          for (j = occupied; j > pos; j--) begin
            held_id[j]   = held_id[j-1];
            held_pri[j]  = held_pri[j-1];
            held_time[j] = held_time[j-1];
          end
          held_id[pos]   = next_task_id[7:0];
          held_pri[pos]  = r.pri;
          held_time[pos] = r.tm;
          occupied++;
          pending_results.push_back('{ST_OK, next_task_id[7:0], r.pri, r.tm, (k + 1 == n)});
          next_task_id++;
        end
      end
      OP_FIND: begin
        find_count++;
        for (pos = 0; pos < occupied; pos++)
          if (held_id[pos] == r.id) break;
        if (pos < occupied)
          pending_results.push_back('{ST_OK, held_id[pos], held_pri[pos], held_time[pos], 1'b1});
        else
          pending_results.push_back(MISS);
      end
      OP_RANK: begin
        rank_count++;
        if (r.rank < occupied)
          pending_results.push_back('{ST_OK, held_id[r.rank], held_pri[r.rank],
                                      held_time[r.rank], 1'b1});
        else
          pending_results.push_back(MISS);
      end
      default: ;
    endcase
  endtask

  task automatic issue_request(input request_t r, input logic typed, input task_result_t res);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {2'b00, r.rank, r.id, r.tm, r.pri, r.count};
    do @(posedge clk); while (!s_tready);
    schedule_results(r);
    // hand-written expectation stands in for the computed one
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(res);
    end
  endtask

  directed_row_t steps [19] = '{
    '{'{OP_RANK,   7'd0,   8'd0,   16'd0,     8'd0,   7'd0},   1'b1, MISS},
    '{'{OP_FIND,   7'd0,   8'd0,   16'd0,     8'd0,   7'd0},   1'b1, MISS},
    '{'{OP_FIND,   7'd0,   8'd0,   16'd0,     8'd255, 7'd0},   1'b1, MISS},
    '{'{OP_UNUSED, 7'd127, 8'd255, 16'hffff,  8'd255, 7'd127}, 1'b0, NONE},
    '{'{OP_ADD,    7'd0,   8'd9,   16'd9,     8'd0,   7'd0},   1'b0, NONE},
    '{'{OP_ADD,    7'd1,   8'd0,   16'd0,     8'd0,   7'd0},   1'b1,
      '{ST_OK, 8'd1, 8'd0, 16'd0, 1'b1}},
    '{'{OP_ADD,    7'd1,   8'd255, 16'hffff,  8'd0,   7'd0},   1'b1,
      '{ST_OK, 8'd2, 8'd255, 16'hffff, 1'b1}},
    '{'{OP_ADD,    7'd3,   8'd255, 16'd0,     8'd0,   7'd0},   1'b0, NONE},
    '{'{OP_ADD,    7'd2,   8'd255, 16'd0,     8'd0,   7'd0},   1'b0, NONE},
    '{'{OP_RANK,   7'd0,   8'd0,   16'd0,     8'd0,   7'd0},   1'b0, NONE},
    '{'{OP_RANK,   7'd0,   8'd0,   16'd0,     8'd0,   7'd6},   1'b0, NONE},
    '{'{OP_RANK,   7'd0,   8'd0,   16'd0,     8'd0,   7'd7},   1'b1, MISS},
    '{'{OP_RANK,   7'd0,   8'd0,   16'd0,     8'd0,   7'd127}, 1'b1, MISS},
    '{'{OP_FIND,   7'd0,   8'd0,   16'd0,     8'd2,   7'd0},   1'b1,
      '{ST_OK, 8'd2, 8'd255, 16'hffff, 1'b1}},
    '{'{OP_FIND,   7'd0,   8'd0,   16'd0,     8'd128, 7'd0},   1'b1, MISS},
    '{'{OP_ADD,    7'd1,   8'd128, 16'h8000,  8'd0,   7'd0},   1'b0, NONE},
    '{'{OP_ADD,    7'd1,   8'd127, 16'd1,     8'd0,   7'd0},   1'b0, NONE},
    '{'{OP_FIND,   7'd0,   8'd0,   16'd0,     8'd9,   7'd0},   1'b0, NONE},
    '{'{OP_RANK,   7'd0,   8'd0,   16'd0,     8'd0,   7'd3},   1'b0, NONE}
  };

  initial begin
    request_t r;
    int pick;
    int effective;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (steps[i])
      issue_request(steps[i].req, steps[i].typed, steps[i].res);
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      r.op    = OP_ADD;
      r.count = 7'($urandom_range(0, 127));
      r.pri   = 8'($urandom_range(0, 255));
      r.tm    = 16'($urandom_range(0, 65535));
      r.id    = 8'($urandom_range(0, 255));
      r.rank  = 7'($urandom_range(0, 127));
      if (pick < 40) begin
        // mostly short adds with clustered keys so ties get exercised
        if ($urandom_range(0, 9) != 0) r.count = 7'($urandom_range(1, 3));
        if ($urandom_range(0, 1) != 0) r.pri = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) != 0) r.tm = 16'($urandom_range(0, 3));
      end else if (pick < 70) begin
        r.op = OP_FIND;
        if (next_task_id > 1 && $urandom_range(0, 3) != 0)
          r.id = 8'($urandom_range(1, next_task_id - 1));
      end else if (pick < 97) begin
        r.op = OP_RANK;
        if (occupied > 0 && $urandom_range(0, 3) != 0)
          r.rank = 7'($urandom_range(0, occupied - 1));
      end else begin
        r.op = OP_UNUSED;
      end
      if (r.op != OP_UNUSED && !(r.op == OP_ADD && r.count == 0))
        effective++;
      steady = (effective >= RANDOM_ITEMS - 25);
      issue_request(r, 1'b0, NONE);
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: accepted %0d adds, %0d lookups, %0d rank reads; checked %0d results",
             add_count, find_count, rank_count, checked_count);
    $display("tb: table filled to %0d entries, %0d adds ran out of ids", occupied, full_hits);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Receiver backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task_result_t seen_result, want_result;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = '{status_t'(m_tdata[1:0]), m_tdata[9:2], m_tdata[17:10],
                      m_tdata[33:18], m_tlast};
      checked_count++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result id %0d status %0d",
                             seen_result.id, seen_result.status));
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.status !== want_result.status)
          flag_error($sformatf("status %0d, want %0d", seen_result.status, want_result.status));
        if (seen_result.id !== want_result.id)
          flag_error($sformatf("out_id %0d, want %0d", seen_result.id, want_result.id));
        if (seen_result.pri !== want_result.pri)
          flag_error($sformatf("out_priority %0d, want %0d", seen_result.pri, want_result.pri));
        if (seen_result.tm !== want_result.tm)
          flag_error($sformatf("time_left %0d, want %0d", seen_result.tm, want_result.tm));
        if (seen_result.last !== want_result.last)
          flag_error($sformatf("last %b, want %b", seen_result.last, want_result.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
